FILE: design/kaj_pkg.sv
// shared types and constants for the k-th ancestor jump table engine
package kaj_pkg;

    localparam int DEF_NODES  = 1024;
    localparam int DEF_LEVELS = 10;

    localparam int NODE_W = 10;
    localparam int HOP_W  = 16;
    localparam int ACT_W  = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_BUILD = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_BUILD,
        CMD_QUERY,
        CMD_ANSWER
    } cmd_op_t;

    // one queued request for the back end
    typedef struct packed {
        cmd_op_t             op;
        logic [NODE_W-1:0]   node;
        logic                link_valid;
        logic [NODE_W-1:0]   link_idx;
        logic                found;
        logic [HOP_W-1:0]    hops;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_B_PREV,
        ST_B_UP,
        ST_B_WRITE,
        ST_Q_STEP,
        ST_Q_CHECK,
        ST_DONE
    } back_state_t;

endpackage

FILE: design/kaj_front.sv
// front end: accepts requests, classifies them and queues work for the back end
module kaj_front #(
    parameter int NODES  = kaj_pkg::DEF_NODES,
    parameter int LEVELS = kaj_pkg::DEF_LEVELS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [kaj_pkg::ACT_W-1:0]  s_action,
    input  logic [kaj_pkg::NODE_W-1:0] s_node,
    input  logic [kaj_pkg::NODE_W-1:0] s_parent_node,
    input  logic                       s_is_root,
    input  logic [kaj_pkg::HOP_W-1:0]  s_hop_count,
    output logic                       q_valid,
    output kaj_pkg::cmd_t              q_head,
    input  logic                       q_pop
);
    import kaj_pkg::*;

    cmd_t               q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    logic node_ok;
    logic parent_ok;
    logic hops_big;
    logic push;
    logic accept;
    cmd_t cmd;

    assign node_ok   = 32'(s_node) < NODES;
    assign parent_ok = 32'(s_parent_node) < NODES;
    assign hops_big  = (32'(s_hop_count) >> LEVELS) != 32'd0;

    assign s_ready = count_reg != Q_CNT_W'(Q_DEPTH);
    assign accept  = s_valid && s_ready;
    assign q_valid = count_reg != '0;
    assign q_head  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        cmd            = '0;
        cmd.op         = CMD_ANSWER;
        cmd.node       = s_node;
        cmd.hops       = s_hop_count;
        push           = 1'b0;
        case (s_action)
            ACT_LOAD: begin
                // loads of nodes outside the tree are dropped here
                push           = node_ok;
                cmd.op         = CMD_LOAD;
                cmd.link_valid = !s_is_root && parent_ok;
                cmd.link_idx   = (!s_is_root && parent_ok) ? s_parent_node : '0;
            end
            ACT_BUILD: begin
                push   = 1'b1;
                cmd.op = CMD_BUILD;
            end
            ACT_QUERY: begin
                push = 1'b1;
                if (!node_ok || hops_big) begin
                    cmd.op    = CMD_ANSWER;
                    cmd.found = 1'b0;
                end else if (s_hop_count == '0) begin
                    cmd.op       = CMD_ANSWER;
                    cmd.found    = 1'b1;
                    cmd.link_idx = s_node;
                end else begin
                    cmd.op = CMD_QUERY;
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept && push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if ((accept && push) && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!(accept && push) && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && push) begin
            q_mem_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

FILE: design/kaj_back.sv
// back end: jump table memory, build sweep, query climb and result register
module kaj_back #(
    parameter int NODES  = kaj_pkg::DEF_NODES,
    parameter int LEVELS = kaj_pkg::DEF_LEVELS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  kaj_pkg::cmd_t              q_head,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [kaj_pkg::NODE_W-1:0] m_ancestor,
    output logic                       m_found
);
    import kaj_pkg::*;

    localparam int NIDX  = $clog2(NODES);
    localparam int EIW   = (NIDX < NODE_W) ? NIDX : NODE_W;
    localparam int ENT_W = EIW + 1;
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DEPTH = NODES * LEVELS;
    localparam int AW    = $clog2(DEPTH);

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [LW-1:0]     lvl_reg, lvl_next;
    logic [NIDX-1:0]   idx_reg, idx_next;
    logic [EIW-1:0]    cur_reg, cur_next;
    logic [LEVELS-1:0] hops_reg, hops_next;
    logic [NODE_W-1:0] res_anc_reg, res_anc_next;
    logic              res_found_reg, res_found_next;
    logic              m_valid_reg, m_valid_next;
    logic [NODE_W-1:0] m_ancestor_reg, m_ancestor_next;
    logic              m_found_reg, m_found_next;

    logic             mem_we, mem_re;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [ENT_W-1:0] wr_data;

    logic           rd_valid;
    logic [EIW-1:0] rd_idx;
    logic [LW-1:0]  lvl_m1;
    logic           build_last;
    logic           out_free;

    function automatic logic [AW-1:0] tab_addr(input logic [LW-1:0] l,
                                               input logic [NIDX-1:0] n);
        return AW'(l) * AW'(NODES) + AW'(n);
    endfunction

    assign rd_valid   = rd_data_reg[EIW];
    assign rd_idx     = rd_data_reg[EIW-1:0];
    assign lvl_m1     = lvl_reg - 1'b1;
    assign build_last = (idx_reg == NIDX'(NODES - 1)) && (lvl_reg == LW'(LEVELS - 1));
    assign out_free   = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_ancestor = m_ancestor_reg;
    assign m_found    = m_found_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_head.op)
                        CMD_LOAD:   state_next = ST_IDLE;
                        CMD_BUILD:  state_next = (LEVELS > 1) ? ST_B_PREV : ST_IDLE;
                        CMD_QUERY:  state_next = ST_Q_STEP;
                        CMD_ANSWER: state_next = ST_DONE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_B_PREV: state_next = ST_B_UP;
            ST_B_UP: begin
                if (rd_valid) begin
                    state_next = ST_B_WRITE;
                end else begin
                    state_next = build_last ? ST_IDLE : ST_B_PREV;
                end
            end
            ST_B_WRITE: state_next = build_last ? ST_IDLE : ST_B_PREV;
            ST_Q_STEP: begin
                if (hops_reg[lvl_reg]) begin
                    state_next = ST_Q_CHECK;
                end else if (lvl_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_Q_CHECK: begin
                state_next = (!rd_valid || lvl_reg == '0) ? ST_DONE : ST_Q_STEP;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        wr_addr         = '0;
        rd_addr         = '0;
        wr_data         = '0;
        lvl_next        = lvl_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        hops_next       = hops_reg;
        res_anc_next    = res_anc_reg;
        res_found_next  = res_found_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_ancestor_next = m_ancestor_reg;
        m_found_next    = m_found_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        CMD_LOAD: begin
                            mem_we  = 1'b1;
                            wr_addr = tab_addr('0, NIDX'(q_head.node));
                            wr_data = {q_head.link_valid, EIW'(q_head.link_idx)};
                        end
                        CMD_BUILD: begin
                            lvl_next = LW'(1);
                            idx_next = '0;
                        end
                        CMD_QUERY: begin
                            lvl_next  = LW'(LEVELS - 1);
                            cur_next  = EIW'(q_head.node);
                            hops_next = LEVELS'(q_head.hops);
                        end
                        CMD_ANSWER: begin
                            res_found_next = q_head.found;
                            res_anc_next   = q_head.link_idx;
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_B_PREV: begin
                mem_re  = 1'b1;
                rd_addr = tab_addr(lvl_m1, idx_reg);
            end
            ST_B_UP: begin
                if (rd_valid) begin
                    mem_re  = 1'b1;
                    rd_addr = tab_addr(lvl_m1, NIDX'(rd_idx));
                end else begin
                    // no ancestor carries upward
                    mem_we  = 1'b1;
                    wr_addr = tab_addr(lvl_reg, idx_reg);
                    wr_data = '0;
                    if (idx_reg == NIDX'(NODES - 1)) begin
                        idx_next = '0;
                        lvl_next = lvl_reg + 1'b1;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_B_WRITE: begin
                mem_we  = 1'b1;
                wr_addr = tab_addr(lvl_reg, idx_reg);
                wr_data = rd_data_reg;
                if (idx_reg == NIDX'(NODES - 1)) begin
                    idx_next = '0;
                    lvl_next = lvl_reg + 1'b1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_Q_STEP: begin
                if (hops_reg[lvl_reg]) begin
                    mem_re  = 1'b1;
                    rd_addr = tab_addr(lvl_reg, NIDX'(cur_reg));
                end else if (lvl_reg == '0) begin
                    res_found_next = 1'b1;
                    res_anc_next   = NODE_W'(cur_reg);
                end else begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            ST_Q_CHECK: begin
                if (!rd_valid) begin
                    // climbed past the root
                    res_found_next = 1'b0;
                    res_anc_next   = '0;
                end else begin
                    cur_next = rd_idx;
                    if (lvl_reg == '0) begin
                        res_found_next = 1'b1;
                        res_anc_next   = NODE_W'(rd_idx);
                    end else begin
                        lvl_next = lvl_reg - 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_ancestor_next = res_anc_reg;
                    m_found_next    = res_found_reg;
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg        <= lvl_next;
        idx_reg        <= idx_next;
        cur_reg        <= cur_next;
        hops_reg       <= hops_next;
        res_anc_reg    <= res_anc_next;
        res_found_reg  <= res_found_next;
        m_ancestor_reg <= m_ancestor_next;
        m_found_reg    <= m_found_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: design/kth_ancestor_jump_table.sv
// top level of the k-th ancestor jump table engine
//
//   channel | direction | ports                                          | moves
//   s_      | in        | action, node, parent_node, is_root, hop_count  | request
//   m_      | out       | ancestor, found                                | one result per query
//
// a load is a single table write; a query climbs the levels from the top, one table read per set bit
// of hop_count, and a trivial query (zero hops, bad node, too many hops) is answered without a
// table read; a build sweeps (LEVELS-1)*NODES entries with one or two reads each through
// the single read port of the table memory
// reset clears control only; table contents are undefined until loaded
// a two-entry request queue keeps s_ready up while the back end works or m_ready stalls, until it fills
module kth_ancestor_jump_table #(
    parameter int NODES  = kaj_pkg::DEF_NODES,
    parameter int LEVELS = kaj_pkg::DEF_LEVELS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [kaj_pkg::ACT_W-1:0]  s_action,
    input  logic [kaj_pkg::NODE_W-1:0] s_node,
    input  logic [kaj_pkg::NODE_W-1:0] s_parent_node,
    input  logic                       s_is_root,
    input  logic [kaj_pkg::HOP_W-1:0]  s_hop_count,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [kaj_pkg::NODE_W-1:0] m_ancestor,
    output logic                       m_found
);
    import kaj_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_head;

    kaj_front #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_node        (s_node),
        .s_parent_node (s_parent_node),
        .s_is_root     (s_is_root),
        .s_hop_count   (s_hop_count),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop)
    );

    kaj_back #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_ancestor (m_ancestor),
        .m_found    (m_found)
    );

`ifndef NO_ASSERTIONS
    // the back end never takes from an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("request queue popped while empty");

    // holding off requests means the queue has work in it
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_valid)
        else $error("s_ready low with an empty request queue");

    // a not-found answer carries a zero index
    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_ancestor == '0))
        else $error("not-found result with non-zero ancestor");
`endif

endmodule

FILE: tb/sv/kth_ancestor_jump_table_checker.sv
// checker for the k-th ancestor engine: mirrors the jump table and compares every answer
module kth_ancestor_jump_table_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [kaj_pkg::ACT_W-1:0]  s_action,
    input  logic [kaj_pkg::NODE_W-1:0] s_node,
    input  logic [kaj_pkg::NODE_W-1:0] s_parent_node,
    input  logic                       s_is_root,
    input  logic [kaj_pkg::HOP_W-1:0]  s_hop_count,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [kaj_pkg::NODE_W-1:0] m_ancestor,
    input  logic                       m_found,
    output int                         mismatches,
    output int                         pending
);
    import kaj_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [NODE_W-1:0] up;
    } lift_link_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              found;
    } answer_t;

    lift_link_t lift_table [DEF_NODES][DEF_LEVELS];
    answer_t    answers_due [$];
    answer_t    oldest;

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // level i of a node is level i-1 of its level i-1 ancestor
    function automatic void rebuild_levels();
        lift_link_t prev;
        for (int lv = 1; lv < DEF_LEVELS; lv++) begin
            for (int n = 0; n < DEF_NODES; n++) begin
                prev = lift_table[n][lv-1];
                if (!prev.ok || int'(prev.up) >= DEF_NODES) begin
                    lift_table[n][lv] = '0;
                end else begin
                    lift_table[n][lv] = lift_table[prev.up][lv-1];
                end
            end
        end
    endfunction

    // climb from the highest set bit of the hop count down
    function automatic answer_t climb(input logic [NODE_W-1:0] start,
                                      input logic [HOP_W-1:0] hops);
        answer_t    res;
        logic [NODE_W-1:0] cur;
        lift_link_t link;
        res = '0;
        cur = start;
        if (int'(start) >= DEF_NODES || (hops >> DEF_LEVELS) != 0) begin
            return res;
        end
        for (int lv = DEF_LEVELS - 1; lv >= 0; lv--) begin
            if (hops[lv]) begin
                link = lift_table[cur][lv];
                if (!link.ok || int'(link.up) >= DEF_NODES) begin
                    return res;
                end
                cur = link.up;
            end
        end
        res.ancestor = cur;
        res.found    = 1'b1;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            answers_due.delete();
            foreach (lift_table[n, lv]) lift_table[n][lv] = '0;
        end else begin
            // take the answer before queuing a new request so nothing matches itself
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch($sformatf("answer with nothing outstanding: ancestor %0d found %0b",
                                              m_ancestor, m_found));
                end else begin
                    oldest = answers_due.pop_front();
                    if (m_ancestor !== oldest.ancestor) begin
                        report_mismatch($sformatf("ancestor %0d, expected %0d",
                                                  m_ancestor, oldest.ancestor));
                    end
                    if (m_found !== oldest.found) begin
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  m_found, oldest.found));
                    end
                end
            end
            if (s_valid && s_ready) begin
                case (action_t'(s_action))
                    ACT_LOAD: begin
                        if (int'(s_node) < DEF_NODES) begin
                            if (s_is_root || int'(s_parent_node) >= DEF_NODES) begin
                                lift_table[s_node][0] = '0;
                            end else begin
                                lift_table[s_node][0] = {1'b1, s_parent_node};
                            end
                        end
                    end
                    ACT_BUILD: rebuild_levels();
                    ACT_QUERY: answers_due = {answers_due, climb(s_node, s_hop_count)};
                    default: ;
                endcase
            end
        end
        pending <= answers_due.size();
    end

endmodule

FILE: tb/sv/kth_ancestor_jump_table_test.sv
// top of the k-th ancestor engine testbench: clock, reset, requests and verdict
module kth_ancestor_jump_table_test;
    import kaj_pkg::*;

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 400;
    // one build sweeps about 9k entries, each through up to three build states
    localparam int QUIET_LIMIT  = 150000;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [ACT_W-1:0]  s_action      = '0;
    logic [NODE_W-1:0] s_node        = '0;
    logic [NODE_W-1:0] s_parent_node = '0;
    logic              s_is_root     = 1'b0;
    logic [HOP_W-1:0]  s_hop_count   = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [NODE_W-1:0] m_ancestor;
    logic              m_found;

    int mismatches;
    int answers_outstanding;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    kth_ancestor_jump_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_node        (s_node),
        .s_parent_node (s_parent_node),
        .s_is_root     (s_is_root),
        .s_hop_count   (s_hop_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ancestor    (m_ancestor),
        .m_found       (m_found)
    );

    kth_ancestor_jump_table_checker checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_node        (s_node),
        .s_parent_node (s_parent_node),
        .s_is_root     (s_is_root),
        .s_hop_count   (s_hop_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ancestor    (m_ancestor),
        .m_found       (m_found),
        .mismatches    (mismatches),
        .pending       (answers_outstanding)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 28);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic [ACT_W-1:0] act, input logic [NODE_W-1:0] nd,
                                input logic [NODE_W-1:0] par, input logic root,
                                input logic [HOP_W-1:0] hops);
        if (!calm && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_node        <= nd;
        s_parent_node <= par;
        s_is_root     <= root;
        s_hop_count   <= hops;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // unused fields carry random bits
    task automatic set_parent(input logic [NODE_W-1:0] nd, input logic [NODE_W-1:0] par,
                              input logic root);
        send_request(ACT_LOAD, nd, par, root, HOP_W'($urandom));
    endtask

    task automatic build_table();
        send_request(ACT_BUILD, NODE_W'($urandom), NODE_W'($urandom), 1'($urandom),
                     HOP_W'($urandom));
    endtask

    task automatic ask_ancestor(input logic [NODE_W-1:0] nd, input logic [HOP_W-1:0] hops);
        send_request(ACT_QUERY, nd, NODE_W'($urandom), 1'($urandom), hops);
    endtask

    task automatic wait_for_answers();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (answers_outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        int pick;
        int count;
        logic [HOP_W-1:0]  hops;
        logic [NODE_W-1:0] nd;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every node gets a parent first so no request ever reads an unwritten entry;
        // mostly long chains so deep hop counts still land
        set_parent('0, NODE_W'($urandom), 1'b1);
        for (int n = 1; n < DEF_NODES; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                set_parent(NODE_W'(n), NODE_W'($urandom), 1'b1);
            end else if (pick < 80) begin
                set_parent(NODE_W'(n), NODE_W'(n - 1), 1'b0);
            end else begin
                set_parent(NODE_W'(n), NODE_W'($urandom_range(0, n - 1)), 1'b0);
            end
        end

        // before the first build only level 0 may be read
        ask_ancestor(10'd1023, 16'd0);
        ask_ancestor(10'd0, 16'd1);
        ask_ancestor(10'd700, 16'd1);
        ask_ancestor(10'd5, 16'hFFFF);
        ask_ancestor(10'd1023, 16'd1024);
        send_request(ACT_NONE, 10'd1023, 10'd1023, 1'b1, 16'hFFFF);
        build_table();

        ask_ancestor(10'd1023, 16'd1023);
        ask_ancestor(10'd1023, 16'd512);
        ask_ancestor(10'd0, 16'd0);
        ask_ancestor(10'd1, 16'd1);
        ask_ancestor(10'd500, 16'd700);
        ask_ancestor(10'd1023, 16'h0155);
        ask_ancestor(10'd1023, 16'h02AA);
        ask_ancestor(10'd1023, 16'h8000);

        // stale table: new level 0 but old higher levels until the next build
        set_parent(10'd1023, 10'd1023, 1'b1);
        ask_ancestor(10'd1023, 16'd1);
        ask_ancestor(10'd1023, 16'd2);
        set_parent(10'd0, 10'd1023, 1'b0);
        ask_ancestor(10'd0, 16'd1);
        wait_for_answers();
        build_table();
        ask_ancestor(10'd0, 16'd3);

        count = 0;
        while (count < RANDOM_ITEMS) begin
            calm = (count >= 160 && count < 240);
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_request(ACT_NONE, NODE_W'($urandom), NODE_W'($urandom), 1'($urandom),
                             HOP_W'($urandom));
            end else begin
                count++;
                if (pick < 3) begin
                    build_table();
                end else if (pick < 25) begin
                    set_parent(NODE_W'($urandom), NODE_W'($urandom),
                               $urandom_range(0, 9) == 0);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 30) begin
                        hops = HOP_W'($urandom_range(0, 15));
                    end else if (pick < 65) begin
                        hops = HOP_W'($urandom_range(0, 1023));
                    end else if (pick < 80) begin
                        hops = HOP_W'(1) << $urandom_range(0, DEF_LEVELS - 1);
                    end else begin
                        hops = HOP_W'($urandom);
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        nd = NODE_W'($urandom);
                    end else begin
                        nd = NODE_W'($urandom_range(900, 1023));
                    end
                    ask_ancestor(nd, hops);
                end
            end
        end
        calm = 1'b0;

        // a closing query waits behind any build still running
        ask_ancestor(10'd1023, 16'd7);
        wait_for_answers();
        repeat (64) @(posedge aclk);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
